>>> sv/border_pixel_kmeans_clustering_core_macros.svh
// ----------------------------------------------------------------------------
// border pixel k-means macros
// assertion helpers used by the core rtl file
// ----------------------------------------------------------------------------
`ifndef BORDER_PIXEL_KMEANS_CLUSTERING_CORE_MACROS_SVH
`define BORDER_PIXEL_KMEANS_CLUSTERING_CORE_MACROS_SVH

// same-cycle implication
`define BPKM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpkm assertion failed");

// next-cycle implication
`define BPKM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpkm assertion failed");

`endif

>>> sv/bpkm_pkg.sv
// ----------------------------------------------------------------------------
// bpkm_pkg
// types, constants and helpers of the border pixel k-means core
// ----------------------------------------------------------------------------
package bpkm_pkg;

  localparam int unsigned DefMaxPoints = 4096;
  localparam int unsigned DefMaxPasses = 64;
  localparam int unsigned NumClusters  = 3;

  localparam int unsigned DsqW  = 34;
  localparam int unsigned RootW = 17;
  localparam int unsigned MeanW = 16;
  localparam int unsigned VarW  = 32;

  localparam logic [VarW-1:0] StopDelta  = 32'd2560;
  localparam logic [VarW-1:0] FirstStop  = 32'd2304;

  localparam logic [11:0] FrameMin  = 12'd3;
  localparam logic [11:0] FrameMax  = 12'd2048;
  localparam logic [6:0]  BorderMin = 7'd1;
  localparam logic [6:0]  BorderMax = 7'd64;

  localparam logic [11:0] WidthRst  = 12'd640;
  localparam logic [11:0] HeightRst = 12'd480;
  localparam logic [6:0]  BorderRst = 7'd8;

  localparam logic [1:0] CfgFrameWidth  = 2'd0;
  localparam logic [1:0] CfgFrameHeight = 2'd1;
  localparam logic [1:0] CfgBorderSize  = 2'd2;

  localparam logic [1:0] ClusterLast = 2'd2;

  function automatic logic [7:0] chan_byte(input logic [23:0] pix, input logic [1:0] ch);
    logic [7:0] b;
    unique case (ch)
      2'd0:    b = pix[23:16];
      2'd1:    b = pix[15:8];
      default: b = pix[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> sv/bpkm_ifs.sv
// ----------------------------------------------------------------------------
// bpkm channel interfaces
// pixel input channel and cluster result channel
// ----------------------------------------------------------------------------
interface bpkm_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] light_value;
  logic [7:0] green_red_value;
  logic [7:0] blue_yellow_value;
  logic       frame_end;

  modport source (output valid, light_value, green_red_value, blue_yellow_value, frame_end,
                  input ready);
  modport sink (input valid, light_value, green_red_value, blue_yellow_value, frame_end,
                output ready);
endinterface

interface bpkm_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cluster_index;
  logic [15:0] mean_light;
  logic [15:0] mean_green_red;
  logic [15:0] mean_blue_yellow;
  logic [12:0] member_count;
  logic [6:0]  passes_done;
  logic        store_overflow;
  logic        last_cluster;

  modport source (output valid, cluster_index, mean_light, mean_green_red, mean_blue_yellow,
                         member_count, passes_done, store_overflow, last_cluster,
                  input ready);
  modport sink (input valid, cluster_index, mean_light, mean_green_red, mean_blue_yellow,
                      member_count, passes_done, store_overflow, last_cluster,
                output ready);
endinterface

>>> sv/border_pixel_kmeans_clustering_core.sv
// ----------------------------------------------------------------------------
// border_pixel_kmeans_clustering_core
// border ring capture and three-cluster k-means over lab pixels
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while a frame streams in; pixels of the
// border ring are written to the point memory, up to MAX_POINTS of them.
// After the word flagged frame_end, the input stalls while clustering
// runs. Each pass sweeps the point memory once, one point at a time: one
// memory read, nine squared terms through a single multiplier, one
// compare, and the serial square root. Between passes up to nine mean
// divisions run in a serial divider. Once the passes end, three result
// words are sent and the input opens again.
// ----------------------------------------------------------------------------
`include "border_pixel_kmeans_clustering_core_macros.svh"

module border_pixel_kmeans_clustering_core #(
  parameter int unsigned MAX_POINTS = bpkm_pkg::DefMaxPoints,
  parameter int unsigned MAX_PASSES = bpkm_pkg::DefMaxPasses
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [11:0]          cfg_data_i,
  bpkm_pixel_if.sink           pix_i,
  bpkm_result_if.source        res_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = AW + 8;
  localparam int unsigned DW = AW + 17;
  localparam int unsigned PW = $clog2(MAX_PASSES + 1);
  localparam int unsigned DQ = bpkm_pkg::DsqW;
  localparam int unsigned MW = bpkm_pkg::MeanW;

  typedef enum logic [3:0] {
    S_STREAM, S_INIT, S_RD, S_SQ, S_FLUSH, S_CMP, S_SQRT, S_CHECK,
    S_DIV_START, S_DIV_WAIT, S_OUT
  } state_e;

  state_e state_q;

  logic [11:0] fw_q, fh_q;
  logic [6:0]  bs_q;
  logic [10:0] col_q, row_q;
  logic [CW-1:0] pcnt_q, idx_q;
  logic          ovf_q, first_q;
  logic [MW-1:0] mean_q [3][3];
  logic [SW-1:0] sum_q  [3][3];
  logic [CW-1:0] cnt_q  [3];
  logic [DQ-1:0] dsq_q  [3];
  logic [31:0]   var_new_q, var_old_q;
  logic [PW-1:0] pass_q;
  logic [1:0]    cl_q, ch_q, prod_cl_q, dv_k_q, dv_c_q, out_k_q;
  logic [31:0]   prod_q;
  logic          prod_vld_q;

  logic          out_vld_q;
  logic [1:0]    o_idx_q;
  logic [15:0]   o_ml_q, o_ma_q, o_mb_q;
  logic [12:0]   o_cnt_q;
  logic [6:0]    o_pass_q;
  logic          o_ovf_q, o_last_q;

  // frame geometry
  logic [11:0] w, h, col, row, col_nx, row_nx;
  logic [6:0]  b;
  logic        in_border, seed0, seed1, in_acc;

  always_comb begin
    w = (fw_q < bpkm_pkg::FrameMin) ? bpkm_pkg::FrameMin :
        (fw_q > bpkm_pkg::FrameMax) ? bpkm_pkg::FrameMax : fw_q;
    h = (fh_q < bpkm_pkg::FrameMin) ? bpkm_pkg::FrameMin :
        (fh_q > bpkm_pkg::FrameMax) ? bpkm_pkg::FrameMax : fh_q;
    b = (bs_q < bpkm_pkg::BorderMin) ? bpkm_pkg::BorderMin :
        (bs_q > bpkm_pkg::BorderMax) ? bpkm_pkg::BorderMax : bs_q;
    col = ({1'b0, col_q} >= w) ? 12'd0 : {1'b0, col_q};
    row = ({1'b0, row_q} >= h) ? 12'd0 : {1'b0, row_q};
    in_border = (row < 12'(b)) || (13'(row) + 13'(b) >= 13'(h)) ||
                (col < 12'(b)) || (13'(col) + 13'(b) >= 13'(w));
    seed0 = (row == 12'd0) && (col == ((w - 12'd1) >> 1));
    seed1 = (col == 12'd0) && (row == ((h - 12'd1) >> 1));
    col_nx = col + 12'd1;
    row_nx = row;
    if (col_nx >= w) begin
      col_nx = 12'd0;
      row_nx = (row + 12'd1 >= h) ? 12'd0 : row + 12'd1;
    end
  end

  assign pix_i.ready = (state_q == S_STREAM);
  assign in_acc      = pix_i.valid && pix_i.ready;

  logic [23:0] pix_word;
  assign pix_word = {pix_i.light_value, pix_i.green_red_value, pix_i.blue_yellow_value};

  // point memory
  logic          pt_we, lb_we, rd_en;
  logic [23:0]   pt_rd;
  logic [1:0]    lb_rd;

  assign pt_we = in_acc && in_border && (pcnt_q < CW'(MAX_POINTS));
  assign lb_we = (state_q == S_CMP);
  assign rd_en = (state_q == S_RD) && (idx_q != pcnt_q);

  bpkm_store #(.MAX_POINTS(MAX_POINTS)) u_store (
    .clk_i      (clk_i),
    .pt_we_i    (pt_we),
    .pt_waddr_i (pcnt_q[AW-1:0]),
    .pt_wdata_i (pix_word),
    .lb_we_i    (lb_we),
    .lb_waddr_i (idx_q[AW-1:0]),
    .lb_wdata_i (new_lab),
    .rd_en_i    (rd_en),
    .rd_addr_i  (idx_q[AW-1:0]),
    .pt_rdata_o (pt_rd),
    .lb_rdata_o (lb_rd)
  );

  // distance terms
  logic [15:0] sq_v, sq_m, sq_diff;
  logic [31:0] prod_d;
  logic [1:0]  new_lab, sel_lab;
  logic [DQ-1:0] best01;

  always_comb begin
    sq_v    = {bpkm_pkg::chan_byte(pt_rd, ch_q), 8'd0};
    sq_m    = mean_q[cl_q][ch_q];
    sq_diff = (sq_v > sq_m) ? sq_v - sq_m : sq_m - sq_v;
    prod_d  = 32'(sq_diff) * 32'(sq_diff);
    new_lab = 2'd0;
    best01  = dsq_q[0];
    if (dsq_q[1] < best01) begin
      new_lab = 2'd1;
      best01  = dsq_q[1];
    end
    if (dsq_q[2] < best01) begin
      new_lab = 2'd2;
    end
    sel_lab = first_q ? new_lab : lb_rd;
  end

  // square root and division units
  logic          sq_start, sq_busy, sq_done;
  logic [DQ-1:0] sq_val;
  logic [bpkm_pkg::RootW-1:0] root;

  always_comb begin
    unique case (sel_lab)
      2'd0:    sq_val = dsq_q[0];
      2'd1:    sq_val = dsq_q[1];
      default: sq_val = dsq_q[2];
    endcase
  end

  assign sq_start = (state_q == S_CMP);

  bpkm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_val),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (root)
  );

  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_num;
  logic [MW-1:0] quot;

  assign div_start = (state_q == S_DIV_START) && (cnt_q[dv_k_q] != '0);
  assign div_num   = DW'({sum_q[dv_k_q][dv_c_q], 8'd0}) + DW'(cnt_q[dv_k_q] >> 1);

  bpkm_divider #(.NUM_W(DW), .DEN_W(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (cnt_q[dv_k_q]),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // convergence check
  logic [31:0] var_dlt;
  logic        stop;
  logic [32:0] var_sum;
  logic [10:0] pass_ext;

  always_comb begin
    var_dlt  = (var_new_q >= var_old_q) ? var_new_q - var_old_q : var_old_q - var_new_q;
    stop     = first_q ? (var_new_q < bpkm_pkg::FirstStop) : (var_dlt < bpkm_pkg::StopDelta);
    var_sum  = {1'b0, var_new_q} + 33'(root);
    pass_ext = 11'(pass_q);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_STREAM;
      fw_q       <= bpkm_pkg::WidthRst;
      fh_q       <= bpkm_pkg::HeightRst;
      bs_q       <= bpkm_pkg::BorderRst;
      col_q      <= '0;
      row_q      <= '0;
      pcnt_q     <= '0;
      idx_q      <= '0;
      ovf_q      <= 1'b0;
      first_q    <= 1'b0;
      mean_q     <= '{default: '{default: '0}};
      sum_q      <= '{default: '{default: '0}};
      cnt_q      <= '{default: '0};
      dsq_q      <= '{default: '0};
      var_new_q  <= '0;
      var_old_q  <= '0;
      pass_q     <= '0;
      cl_q       <= '0;
      ch_q       <= '0;
      prod_cl_q  <= '0;
      prod_q     <= '0;
      prod_vld_q <= 1'b0;
      dv_k_q     <= '0;
      dv_c_q     <= '0;
      out_k_q    <= '0;
      out_vld_q  <= 1'b0;
      o_idx_q    <= '0;
      o_ml_q     <= '0;
      o_ma_q     <= '0;
      o_mb_q     <= '0;
      o_cnt_q    <= '0;
      o_pass_q   <= '0;
      o_ovf_q    <= 1'b0;
      o_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bpkm_pkg::CfgFrameWidth:  fw_q <= cfg_data_i;
          bpkm_pkg::CfgFrameHeight: fh_q <= cfg_data_i;
          bpkm_pkg::CfgBorderSize:  bs_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end

      prod_vld_q <= (state_q == S_SQ);
      if (prod_vld_q) begin
        dsq_q[prod_cl_q] <= dsq_q[prod_cl_q] + DQ'(prod_q);
      end

      if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_STREAM: begin
          if (in_acc) begin
            if (in_border) begin
              if (pcnt_q < CW'(MAX_POINTS)) begin
                pcnt_q <= pcnt_q + CW'(1);
              end else begin
                ovf_q <= 1'b1;
              end
            end
            if (seed0) begin
              mean_q[0] <= '{{pix_i.light_value, 8'd0}, {pix_i.green_red_value, 8'd0},
                             {pix_i.blue_yellow_value, 8'd0}};
            end
            if (seed1) begin
              mean_q[1] <= '{{pix_i.light_value, 8'd0}, {pix_i.green_red_value, 8'd0},
                             {pix_i.blue_yellow_value, 8'd0}};
            end
            col_q <= col_nx[10:0];
            row_q <= row_nx[10:0];
            if (pix_i.frame_end) begin
              mean_q[2] <= '{{pix_i.light_value, 8'd0}, {pix_i.green_red_value, 8'd0},
                             {pix_i.blue_yellow_value, 8'd0}};
              first_q   <= 1'b1;
              pass_q    <= '0;
              var_old_q <= '0;
              state_q   <= S_INIT;
            end
          end
        end
        S_INIT: begin
          sum_q     <= '{default: '{default: '0}};
          cnt_q     <= '{default: '0};
          var_new_q <= '0;
          idx_q     <= '0;
          state_q   <= S_RD;
        end
        S_RD: begin
          if (idx_q == pcnt_q) begin
            state_q <= S_CHECK;
          end else begin
            dsq_q   <= '{default: '0};
            cl_q    <= '0;
            ch_q    <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          prod_q    <= prod_d;
          prod_cl_q <= cl_q;
          if (ch_q == 2'd2) begin
            ch_q <= '0;
            if (cl_q == 2'd2) begin
              state_q <= S_FLUSH;
            end else begin
              cl_q <= cl_q + 2'd1;
            end
          end else begin
            ch_q <= ch_q + 2'd1;
          end
        end
        S_FLUSH: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          cnt_q[new_lab]    <= cnt_q[new_lab] + CW'(1);
          sum_q[new_lab][0] <= sum_q[new_lab][0] + SW'(pt_rd[23:16]);
          sum_q[new_lab][1] <= sum_q[new_lab][1] + SW'(pt_rd[15:8]);
          sum_q[new_lab][2] <= sum_q[new_lab][2] + SW'(pt_rd[7:0]);
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            var_new_q <= var_sum[32] ? '1 : var_sum[31:0];
            idx_q     <= idx_q + CW'(1);
            state_q   <= S_RD;
          end
        end
        S_CHECK: begin
          if (pass_q >= PW'(MAX_PASSES) || stop) begin
            out_k_q <= '0;
            state_q <= S_OUT;
          end else begin
            first_q   <= 1'b0;
            var_old_q <= var_new_q;
            dv_k_q    <= '0;
            dv_c_q    <= '0;
            state_q   <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          if (cnt_q[dv_k_q] != '0) begin
            state_q <= S_DIV_WAIT;
          end else if (dv_k_q == 2'd2) begin
            pass_q  <= pass_q + PW'(1);
            state_q <= S_INIT;
          end else begin
            dv_k_q <= dv_k_q + 2'd1;
            dv_c_q <= '0;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            mean_q[dv_k_q][dv_c_q] <= quot;
            if (dv_c_q == 2'd2) begin
              dv_c_q <= '0;
              if (dv_k_q == 2'd2) begin
                pass_q  <= pass_q + PW'(1);
                state_q <= S_INIT;
              end else begin
                dv_k_q  <= dv_k_q + 2'd1;
                state_q <= S_DIV_START;
              end
            end else begin
              dv_c_q  <= dv_c_q + 2'd1;
              state_q <= S_DIV_START;
            end
          end
        end
        S_OUT: begin
          if (!out_vld_q || res_o.ready) begin
            out_vld_q <= 1'b1;
            o_idx_q   <= out_k_q;
            o_ml_q    <= mean_q[out_k_q][0];
            o_ma_q    <= mean_q[out_k_q][1];
            o_mb_q    <= mean_q[out_k_q][2];
            o_cnt_q   <= 13'(cnt_q[out_k_q]);
            o_pass_q  <= (pass_ext > 11'd127) ? 7'd127 : pass_ext[6:0];
            o_ovf_q   <= ovf_q;
            o_last_q  <= (out_k_q == bpkm_pkg::ClusterLast);
            if (out_k_q == bpkm_pkg::ClusterLast) begin
              col_q   <= '0;
              row_q   <= '0;
              pcnt_q  <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_STREAM;
            end else begin
              out_k_q <= out_k_q + 2'd1;
            end
          end
        end
        default: state_q <= S_STREAM;
      endcase
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.cluster_index    = o_idx_q;
  assign res_o.mean_light       = o_ml_q;
  assign res_o.mean_green_red   = o_ma_q;
  assign res_o.mean_blue_yellow = o_mb_q;
  assign res_o.member_count     = o_cnt_q;
  assign res_o.passes_done      = o_pass_q;
  assign res_o.store_overflow   = o_ovf_q;
  assign res_o.last_cluster     = o_last_q;

  `BPKM_ASSERT_IMP(a_pcnt_bound, clk_i, rst_ni, 1'b1, pcnt_q <= CW'(MAX_POINTS))
  `BPKM_ASSERT_IMP(a_sqrt_idle, clk_i, rst_ni, sq_start, !sq_busy)
  `BPKM_ASSERT_NXT(a_div_runs, clk_i, rst_ni, div_start, div_busy)
  `BPKM_ASSERT_IMP(a_out_src, clk_i, rst_ni, $rose(out_vld_q), $past(state_q == S_OUT))

endmodule

>>> sv/bpkm_store.sv
// ----------------------------------------------------------------------------
// bpkm_store
// point and label memories, one write and one registered read each
// ----------------------------------------------------------------------------
module bpkm_store #(
  parameter int unsigned MAX_POINTS = bpkm_pkg::DefMaxPoints
) (
  input  logic                          clk_i,
  input  logic                          pt_we_i,
  input  logic [$clog2(MAX_POINTS)-1:0] pt_waddr_i,
  input  logic [23:0]                   pt_wdata_i,
  input  logic                          lb_we_i,
  input  logic [$clog2(MAX_POINTS)-1:0] lb_waddr_i,
  input  logic [1:0]                    lb_wdata_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr_i,
  output logic [23:0]                   pt_rdata_o,
  output logic [1:0]                    lb_rdata_o
);

  logic [23:0] pt_mem [MAX_POINTS];
  logic [1:0]  lb_mem [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (pt_we_i) begin
      pt_mem[pt_waddr_i] <= pt_wdata_i;
    end
    if (rd_en_i) begin
      pt_rdata_o <= pt_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lb_we_i) begin
      lb_mem[lb_waddr_i] <= lb_wdata_i;
    end
    if (rd_en_i) begin
      lb_rdata_o <= lb_mem[rd_addr_i];
    end
  end

endmodule

>>> sv/bpkm_isqrt.sv
// ----------------------------------------------------------------------------
// bpkm_isqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module bpkm_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bpkm_pkg::DsqW-1:0]    value_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [bpkm_pkg::RootW-1:0]   root_o
);

  localparam int unsigned W = bpkm_pkg::DsqW;

  logic         busy_q, done_q;
  logic [W-1:0] v_q, r_q, bit_q;
  logic [W-1:0] trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      r_q   <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = r_q[bpkm_pkg::RootW-1:0];

endmodule

>>> sv/bpkm_divider.sv
// ----------------------------------------------------------------------------
// bpkm_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bpkm_divider #(
  parameter int unsigned NUM_W = 28,
  parameter int unsigned DEN_W = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [DEN_W-1:0]              den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [bpkm_pkg::MeanW-1:0]    quot_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q[bpkm_pkg::MeanW-1:0];

endmodule
